/* src/unsorted_list_min_max_remove_macros.svh */
// Assertion helpers shared by the list block.
`ifndef UNSORTED_LIST_MIN_MAX_REMOVE_MACROS_SVH
`define UNSORTED_LIST_MIN_MAX_REMOVE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ULMMR_ASSERT_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ULMMR_ASSERT_NEXT(name, trig, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define ULMMR_ASSERT_SAME(name, trig, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

`endif

/* src/ulmmr_pkg.sv */
package ulmmr_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W = 5;
   localparam int POS_W = 4;
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] REG_CAPACITY = 1'b0;
   localparam logic [CNT_W-1:0] CAPACITY_RESET = 5'd16;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_MIN = 2'd1,
      CMD_MAX = 2'd2,
      CMD_AT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SHIFT,
      ST_RESULT
   } state_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      cmd_type                  mode;
      logic [CNT_W-1:0]         target;
      logic signed [DATA_W-1:0] new_value;
   } cell_ctrl_type;

   // Running search result handed from one cell to the next.
   typedef struct packed {
      logic                     tok;
      logic                     found;
      logic signed [DATA_W-1:0] best;
      logic [CNT_W-1:0]         idx;
   } scan_type;

endpackage

/* src/ulmmr_cell.sv */
module ulmmr_cell
   import ulmmr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctrl_type            ctrl,
   input  logic [CNT_W-1:0]         my_idx,
   input  logic                     valid,
   input  logic                     add_en,
   input  logic                     shift_en,
   input  logic signed [DATA_W-1:0] next_value,
   input  scan_type                 scan_in,
   output scan_type                 scan_out,
   output logic signed [DATA_W-1:0] entry
);

   logic signed [DATA_W-1:0] entry_ff;
   scan_type                 scan_ff;
   scan_type                 scan_in_next;
   logic                     take;

   always_comb begin
      case (ctrl.mode)
         CMD_MIN: take = valid && (!scan_in.found || (entry_ff < scan_in.best));
         CMD_MAX: take = valid && (!scan_in.found || (entry_ff > scan_in.best));
         CMD_AT:  take = valid && (my_idx == ctrl.target);
         default: take = 1'b0;
      endcase
      scan_in_next = scan_in;
      if (take) begin
         scan_in_next.found = 1'b1;
         scan_in_next.best  = entry_ff;
         scan_in_next.idx   = my_idx;
      end
   end

   // Only the token needs a reset; the rest follows it.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.tok <= 1'b0;
      end else begin
         scan_ff.tok <= scan_in.tok;
      end
      scan_ff.found <= scan_in_next.found;
      scan_ff.best  <= scan_in_next.best;
      scan_ff.idx   <= scan_in_next.idx;
   end

   always_ff @(posedge clock) begin
      if (add_en) begin
         entry_ff <= ctrl.new_value;
      end else if (shift_en) begin
         entry_ff <= next_value;
      end
   end

   assign scan_out = scan_ff;
   assign entry    = entry_ff;

endmodule

/* src/unsorted_list_min_max_remove.sv */
// Channel   Direction  Handshake        Contents
// req       in         tvalid/tready    tuser: cmd; tdata: value, position
// rsp       out        tvalid/tready    tuser: status; tdata: value, count, flags
// csr       in         APB, pready = 1  capacity register at address 0
//
// Add and every failed command go from EXEC to RESULT, which loads the registered rsp
// output. Min scans in SCAN, and the removals (Max, At) scan and then compact in SHIFT:
// the search token walks the row of cells one cell a cycle. New items wait for IDLE.
// Synchronous reset empties the list and sets capacity to 16; no clearing pass.
// A result waiting on rsp does not block acceptance of the next item, but that item's
// result then waits in the block and holds off the input until rsp is free.
`include "unsorted_list_min_max_remove_macros.svh"

module unsorted_list_min_max_remove
   import ulmmr_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] value, [35:32] position, [39:36] zero
   input  logic [39:0]           req_tdata,
   // [1:0] cmd
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] result_value, [36:32] count, [37] is_empty, [38] is_full, [39] zero
   output logic [39:0]           rsp_tdata,
   // [1:0] status
   output logic [1:0]            rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         capacity_ff, capacity_in;
   logic [CNT_W-1:0]         rm_idx_ff, rm_idx_in;
   logic signed [DATA_W-1:0] res_value_ff, res_value_in;
   status_type               res_status_ff, res_status_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic                     rsp_full_ff, rsp_full_in;

   logic [CNT_W-1:0]         cap_eff;
   logic                     scan_start, add_go, shift_go, rsp_load;
   cell_ctrl_type            ctrl;
   scan_type                 scan_vec [DEPTH+1];
   logic signed [DATA_W-1:0] entry_vec [DEPTH];
   logic [DEPTH-1:0]         tok_vec;
   scan_type                 scan_last;

   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (int'(capacity_ff) > DEPTH) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = capacity_ff;
      end
   end

   assign ctrl.mode      = cmd_ff;
   assign ctrl.target    = {1'b0, pos_ff};
   assign ctrl.new_value = value_ff;

   assign scan_vec[0].tok   = scan_start;
   assign scan_vec[0].found = 1'b0;
   assign scan_vec[0].best  = '0;
   assign scan_vec[0].idx   = '0;
   assign scan_last         = scan_vec[DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] next_value;

      if (i < DEPTH - 1) begin : g_next
         assign next_value = entry_vec[i+1];
      end else begin : g_end
         assign next_value = '0;
      end

      ulmmr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .my_idx     (CNT_W'(i)),
         .valid      (int'(count_ff) > i),
         .add_en     (add_go && (int'(count_ff) == i)),
         .shift_en   (shift_go && (i >= int'(rm_idx_ff))),
         .next_value (next_value),
         .scan_in    (scan_vec[i]),
         .scan_out   (scan_vec[i+1]),
         .entry      (entry_vec[i])
      );

      assign tok_vec[i] = scan_vec[i+1].tok;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      rm_idx_in     = rm_idx_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      scan_start    = 1'b0;
      add_go        = 1'b0;
      shift_go      = 1'b0;
      rsp_load      = 1'b0;
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tuser);
               value_in = req_tdata[31:0];
               pos_in   = req_tdata[35:32];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_value_in  = '0;
            res_status_in = STATUS_OK;
            state_in      = ST_RESULT;
            unique case (cmd_ff)
               CMD_ADD: begin
                  if (count_ff >= cap_eff) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     add_go   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               CMD_MIN, CMD_MAX: begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                  end else begin
                     scan_start = 1'b1;
                     state_in   = ST_SCAN;
                  end
               end
               CMD_AT: begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                  end else if ({1'b0, pos_ff} >= count_ff) begin
                     res_status_in = STATUS_RANGE;
                  end else begin
                     scan_start = 1'b1;
                     state_in   = ST_SCAN;
                  end
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            if (scan_last.tok) begin
               res_value_in = scan_last.best;
               rm_idx_in    = scan_last.idx;
               state_in     = (cmd_ff == CMD_MIN) ? ST_RESULT : ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            shift_go = 1'b1;
            count_in = count_ff - CNT_W'(1);
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_status_in = res_status_ff;
         rsp_count_in  = count_ff;
         rsp_empty_in  = (count_ff == '0);
         rsp_full_in   = (count_ff >= cap_eff);
      end
   end

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == REG_CAPACITY)) begin
         capacity_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      rm_idx_ff     <= rm_idx_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_full_ff, rsp_empty_ff, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_CAPACITY) ? {{(32-CNT_W){1'b0}}, capacity_ff} : '0;

   // At most one search runs, so the token sits in at most one cell.
   `ULMMR_ASSERT_ALWAYS(a_one_token, $onehot0(tok_vec), "search token duplicated")
   // A search is only launched on a non-empty list, so it always ends with a hit.
   `ULMMR_ASSERT_SAME(a_scan_found, scan_last.tok, scan_last.found, "search ended without hit")
   // Compaction removes exactly one entry.
   `ULMMR_ASSERT_NEXT(a_shift_count, state_ff == ST_SHIFT,
                      count_ff == $past(count_ff) - CNT_W'(1), "count not decremented")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import ulmmr_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int PHASES = 9;
   localparam int ITEMS_PER_PHASE = 110;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      status_type               status;
      logic [CNT_W-1:0]         count;
      logic                     is_empty;
      logic                     is_full;
   } list_result_type;

   typedef struct {
      cmd_type          cmd;
      logic [31:0]      value;
      logic [POS_W-1:0] pos;
      bit               typed;
      list_result_type  result;
   } command_row_type;

   localparam list_result_type UNTYPED = '{32'h0, STATUS_OK, 5'd0, 1'b0, 1'b0};

   // Opening rows run at the reset capacity of 16. The first fifteen rows can be
   // followed by hand; the rest are left to the list predictor.
   command_row_type directed_rows [24] = '{
      '{CMD_MIN, 32'h0000_0000, 4'd0,  1'b1, '{32'h0, STATUS_EMPTY, 5'd0, 1'b1, 1'b0}},
      '{CMD_MAX, 32'h0000_0000, 4'd0,  1'b1, '{32'h0, STATUS_EMPTY, 5'd0, 1'b1, 1'b0}},
      '{CMD_AT,  32'h0000_0000, 4'd15, 1'b1, '{32'h0, STATUS_EMPTY, 5'd0, 1'b1, 1'b0}},
      '{CMD_ADD, 32'h7FFF_FFFF, 4'd0,  1'b1, '{32'h0, STATUS_OK, 5'd1, 1'b0, 1'b0}},
      '{CMD_ADD, 32'h8000_0000, 4'd0,  1'b1, '{32'h0, STATUS_OK, 5'd2, 1'b0, 1'b0}},
      '{CMD_ADD, 32'hFFFF_FFFF, 4'd0,  1'b1, '{32'h0, STATUS_OK, 5'd3, 1'b0, 1'b0}},
      '{CMD_ADD, 32'h8000_0000, 4'd0,  1'b1, '{32'h0, STATUS_OK, 5'd4, 1'b0, 1'b0}},
      '{CMD_ADD, 32'h7FFF_FFFF, 4'd0,  1'b1, '{32'h0, STATUS_OK, 5'd5, 1'b0, 1'b0}},
      '{CMD_MIN, 32'h0000_0000, 4'd0,  1'b1,
        '{32'h8000_0000, STATUS_OK, 5'd5, 1'b0, 1'b0}},
      '{CMD_MAX, 32'h0000_0000, 4'd0,  1'b1,
        '{32'h7FFF_FFFF, STATUS_OK, 5'd4, 1'b0, 1'b0}},
      '{CMD_AT,  32'h0000_0000, 4'd15, 1'b1, '{32'h0, STATUS_RANGE, 5'd4, 1'b0, 1'b0}},
      '{CMD_AT,  32'h0000_0000, 4'd4,  1'b1, '{32'h0, STATUS_RANGE, 5'd4, 1'b0, 1'b0}},
      '{CMD_AT,  32'h0000_0000, 4'd1,  1'b1,
        '{32'hFFFF_FFFF, STATUS_OK, 5'd3, 1'b0, 1'b0}},
      '{CMD_MAX, 32'h0000_0000, 4'd0,  1'b1,
        '{32'h7FFF_FFFF, STATUS_OK, 5'd2, 1'b0, 1'b0}},
      '{CMD_AT,  32'h0000_0000, 4'd0,  1'b1,
        '{32'h8000_0000, STATUS_OK, 5'd1, 1'b0, 1'b0}},
      '{CMD_ADD, 32'h0000_0000, 4'd0,  1'b0, UNTYPED},
      '{CMD_ADD, 32'h0000_0001, 4'd0,  1'b0, UNTYPED},
      '{CMD_MIN, 32'h0000_0000, 4'd0,  1'b0, UNTYPED},
      '{CMD_ADD, 32'h5555_AAAA, 4'd0,  1'b0, UNTYPED},
      '{CMD_ADD, 32'hAAAA_5555, 4'd0,  1'b0, UNTYPED},
      '{CMD_MAX, 32'h0000_0000, 4'd0,  1'b0, UNTYPED},
      '{CMD_AT,  32'h0000_0000, 4'd0,  1'b0, UNTYPED},
      '{CMD_AT,  32'h0000_0000, 4'd10, 1'b0, UNTYPED},
      '{CMD_MIN, 32'h0000_0000, 4'd0,  1'b0, UNTYPED}
   };

   logic [31:0] corner_values [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [31:0] value, [35:32] position, [39:36] zero
   logic [39:0]           req_tdata = '0;
   // [1:0] cmd
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [31:0] result_value, [36:32] count, [37] is_empty, [38] is_full, [39] zero
   logic [39:0]           rsp_tdata;
   // [1:0] status
   logic [1:0]            rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   logic signed [DATA_W-1:0] stored_values [$];
   logic [CNT_W-1:0]         capacity_reg = CAPACITY_RESET;
   list_result_type          awaited_results [$];
   int                       mismatches = 0;
   int                       send_idle_pct = 0;
   int                       recv_stall_pct = 0;
   int                       hold_left = 0;
   bit                       long_hold_req = 1'b0;

   unsorted_list_min_max_remove #(.DEPTH(LIST_DEPTH)) dut (.*);

   always #5 clock = ~clock;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic int effective_capacity();
      int cap;
      cap = int'(capacity_reg);
      if (cap < 1) cap = 1;
      if (cap > LIST_DEPTH) cap = LIST_DEPTH;
      return cap;
   endfunction

   // Applies one command to the list copy and returns the result it should give.
   function automatic list_result_type apply_command(cmd_type cmd, logic signed [31:0] value,
                                                     logic [POS_W-1:0] pos);
      list_result_type r;
      int cap;
      int best;
      cap = effective_capacity();
      r = UNTYPED;
      case (cmd)
         CMD_ADD: begin
            if (stored_values.size() >= cap) r.status = STATUS_FULL;
            else stored_values.push_back(value);
         end
         CMD_MIN: begin
            if (stored_values.size() == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               best = 0;
               for (int i = 1; i < stored_values.size(); i++)
                  if (stored_values[i] < stored_values[best]) best = i;
               r.value = stored_values[best];
            end
         end
         CMD_MAX: begin
            if (stored_values.size() == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               best = 0;
               for (int i = 1; i < stored_values.size(); i++)
                  if (stored_values[i] > stored_values[best]) best = i;
               r.value = stored_values[best];
               stored_values.delete(best);
            end
         end
         default: begin
            if (stored_values.size() == 0) begin
               r.status = STATUS_EMPTY;
            end else if (int'(pos) >= stored_values.size()) begin
               r.status = STATUS_RANGE;
            end else begin
               r.value = stored_values[pos];
               stored_values.delete(int'(pos));
            end
         end
      endcase
      r.count = CNT_W'(stored_values.size());
      r.is_empty = (stored_values.size() == 0);
      r.is_full = (stored_values.size() >= cap);
      return r;
   endfunction

   // Offers one item, leaving tvalid high afterwards so back-to-back items need no gap.
   task automatic send_command(cmd_type cmd, logic [31:0] value, logic [POS_W-1:0] pos,
                               bit typed, list_result_type typed_result);
      list_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {4'b0, pos, value};
      do @(posedge clock); while (!req_tready);
      predicted = apply_command(cmd, value, pos);
      awaited_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   task automatic check_capacity_readback();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= REG_CAPACITY;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {27'd0, capacity_reg})
         report_mismatch("capacity readback", csr_prdata, {27'd0, capacity_reg});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_capacity(logic [31:0] word);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_CAPACITY;
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      capacity_reg = word[CNT_W-1:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      check_capacity_readback();
   endtask

   task automatic check_result();
      list_result_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("result with nothing awaited", rsp_tdata[31:0], 32'h0);
         return;
      end
      want = awaited_results.pop_front();
      if (rsp_tdata[31:0] !== want.value)
         report_mismatch("result_value", rsp_tdata[31:0], want.value);
      if (rsp_tuser !== want.status)
         report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
      if (rsp_tdata[36:32] !== want.count)
         report_mismatch("count", 32'(rsp_tdata[36:32]), 32'(want.count));
      if (rsp_tdata[37] !== want.is_empty)
         report_mismatch("is_empty", 32'(rsp_tdata[37]), 32'(want.is_empty));
      if (rsp_tdata[38] !== want.is_full)
         report_mismatch("is_full", 32'(rsp_tdata[38]), 32'(want.is_full));
   endtask

   // Result side: checks each accepted item, then picks tready for the next edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int fill;
      int cap;
      int roll;
      logic [31:0] cap_word;
      logic [31:0] value;
      logic [POS_W-1:0] pos;
      cmd_type cmd;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_capacity_readback();

      foreach (directed_rows[i])
         send_command(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].pos,
                      directed_rows[i].typed, directed_rows[i].result);

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         case (p)
            0: cap_word = 32'd0;
            1: cap_word = 32'd1;
            2: cap_word = 32'd31;
            3: cap_word = 32'd2;
            5: cap_word = $urandom_range(3, 15);
            6: cap_word = $urandom_range(17, 30);
            7: cap_word = 32'd3;
            default: cap_word = 32'd16;
         endcase
         // Bits above the register are don't-care but still exercised.
         write_capacity(($urandom & 32'hFFFF_FFE0) | cap_word);
         case (p % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 46; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 46; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            fill = stored_values.size();
            cap = effective_capacity();
            roll = $urandom_range(99);
            // Lean towards adds when the list is empty and away from them when it is full,
            // so that both the full and the empty corner are visited often.
            if (fill == 0)
               cmd = (roll < 70) ? CMD_ADD : cmd_type'($urandom_range(1, 3));
            else if (fill >= cap)
               cmd = (roll < 20) ? CMD_ADD : cmd_type'($urandom_range(1, 3));
            else if (roll < 50)
               cmd = CMD_ADD;
            else if (roll < 62)
               cmd = CMD_MIN;
            else if (roll < 80)
               cmd = CMD_MAX;
            else
               cmd = CMD_AT;

            roll = $urandom_range(99);
            if (roll < 25) value = $urandom_range(4) - 2;
            else if (roll < 40) value = corner_values[$urandom_range(3)];
            else value = $urandom;

            if (fill > 0 && $urandom_range(99) < 80) pos = POS_W'($urandom_range(fill - 1));
            else pos = POS_W'($urandom_range(15));

            if (p == 2 && n == 20) long_hold_req = 1'b1;
            if (p == 4 && n == 55) drain_results();
            send_command(cmd, value, pos, 1'b0, UNTYPED);
         end
      end

      drain_results();
      repeat (2 * LIST_DEPTH + 8) @(posedge clock);
      if (mismatches == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
